// File: src/chkx_pkg.sv
// ----------------------------------------------------------------------------
// chkx_pkg
// Shared types, constants and round functions for the ChaCha keystream block.
// ----------------------------------------------------------------------------
package chkx_pkg;

    localparam int RoundsDefault = 20;
    localparam int QueueDepthDefault = 2;
    localparam int NumCfgRegs = 8;
    localparam int CfgIdxW = 3;

    // Register index of the counter and low nonce word; a write here restarts
    // the keystream at a new block.
    localparam logic [CfgIdxW-1:0] CfgCtrNonce = CfgIdxW'(6);

    typedef logic [15:0][31:0] t_state;
    typedef logic [7:0][63:0] t_block;
    typedef logic [NumCfgRegs-1:0][63:0] t_cfg_regs;

    typedef struct packed {
        logic [63:0] data;
        logic        mode;
        logic        start;
        logic [31:0] ctr;
        logic [2:0]  pos;
    } t_item;

    typedef struct packed {
        logic               we;
        logic [CfgIdxW-1:0] idx;
        logic [63:0]        data;
    } t_cfg_wr;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic t_state quarter(input t_state s, input int a, input int b,
                                       input int c, input int d);
        t_state t;
        t = s;
        t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 16);
        t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 12);
        t[a] = t[a] + t[b]; t[d] = rotl(t[d] ^ t[a], 8);
        t[c] = t[c] + t[d]; t[b] = rotl(t[b] ^ t[c], 7);
        return t;
    endfunction

    // One column pass or one diagonal pass; the four quarter rounds of a
    // pass touch disjoint words and so work side by side.
    function automatic t_state chacha_round(input t_state s, input logic diag);
        t_state t;
        t = s;
        if (!diag) begin
            t = quarter(t, 0, 4, 8, 12);
            t = quarter(t, 1, 5, 9, 13);
            t = quarter(t, 2, 6, 10, 14);
            t = quarter(t, 3, 7, 11, 15);
        end else begin
            t = quarter(t, 0, 5, 10, 15);
            t = quarter(t, 1, 6, 11, 12);
            t = quarter(t, 2, 7, 8, 13);
            t = quarter(t, 3, 4, 9, 14);
        end
        return t;
    endfunction

endpackage

// File: src/chkx_front.sv
// ----------------------------------------------------------------------------
// chkx_front
// Request intake: tags each word with its block position and block counter.
// ----------------------------------------------------------------------------
module chkx_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  chkx_pkg::t_cfg_wr i_cfg,
    input  logic             i_push,
    input  logic [63:0]      i_data_in,
    input  logic             i_mode,
    input  logic             i_q_full,
    output logic             o_full,
    output logic             o_q_push,
    output chkx_pkg::t_item  o_q_item
);

    logic [2:0]  r_pos;
    logic [31:0] r_ctr;
    logic [2:0]  n_pos;
    logic [31:0] n_ctr;
    logic        accept;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    always_comb begin
        o_q_item.data  = i_data_in;
        o_q_item.mode  = i_mode;
        o_q_item.start = (r_pos == 3'd0);
        o_q_item.ctr   = r_ctr;
        o_q_item.pos   = r_pos;
    end

    always_comb begin
        n_pos = r_pos;
        n_ctr = r_ctr;
        if (i_cfg.we && i_cfg.idx == chkx_pkg::CfgCtrNonce) begin
            n_pos = 3'd0;
            n_ctr = i_cfg.data[31:0];
        end else if (accept) begin
            n_pos = r_pos + 3'd1;
            // The counter moves on once the first word of a block is taken.
            if (r_pos == 3'd0) begin
                n_ctr = r_ctr + 32'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
            r_ctr <= 32'd0;
        end else begin
            r_pos <= n_pos;
            r_ctr <= n_ctr;
        end
    end

endmodule

// File: src/chkx_queue.sv
// ----------------------------------------------------------------------------
// chkx_queue
// Small request queue between the intake and the cipher core.
// ----------------------------------------------------------------------------
module chkx_queue #(
    parameter int DEPTH = chkx_pkg::QueueDepthDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  chkx_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output chkx_pkg::t_item o_item
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    chkx_pkg::t_item r_mem [DEPTH];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == FullCnt);
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: src/chkx_back.sv
// ----------------------------------------------------------------------------
// chkx_back
// Cipher core: runs the block function one round per cycle, holds the
// current keystream block and drives the result register.
// ----------------------------------------------------------------------------
module chkx_back #(
    parameter int ROUNDS = chkx_pkg::RoundsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  chkx_pkg::t_state i_init,
    input  logic             i_q_empty,
    input  chkx_pkg::t_item  i_q_item,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [63:0]      o_data_out,
    output logic             o_busy
);

    // An odd round count is rounded up to whole double rounds.
    localparam int NumRounds = ((ROUNDS + 1) / 2) * 2;
    localparam int RndW = $clog2(NumRounds);
    localparam logic [RndW-1:0] LastRnd = RndW'(NumRounds - 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ROUND = 2'd1;
    localparam logic [1:0] S_FINAL = 2'd2;
    localparam logic [1:0] S_EMIT  = 2'd3;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [RndW-1:0]  r_rnd;
    logic [RndW-1:0]  n_rnd;
    chkx_pkg::t_state r_w;
    chkx_pkg::t_state n_w;
    chkx_pkg::t_block r_ks;
    chkx_pkg::t_state init_s;
    chkx_pkg::t_state fin_s;
    chkx_pkg::t_block fin_b;
    logic             r_out_valid;
    logic [63:0]      r_out_data;
    logic             out_free;
    logic             emit;
    logic             ks_we;
    logic [63:0]      ks_word;
    logic [63:0]      res_word;

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        init_s     = i_init;
        init_s[12] = i_q_item.ctr;
        for (int k = 0; k < 16; k++) begin
            fin_s[k] = r_w[k] + init_s[k];
        end
        fin_b = fin_s;
    end

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        n_w     = r_w;
        o_q_pop = 1'b0;
        emit    = 1'b0;
        ks_we   = 1'b0;
        ks_word = r_ks[i_q_item.pos];
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_item.start) begin
                        n_w     = init_s;
                        n_rnd   = '0;
                        n_state = S_ROUND;
                    end else if (out_free) begin
                        emit    = 1'b1;
                        o_q_pop = 1'b1;
                    end
                end
            end
            S_ROUND: begin
                n_w   = chkx_pkg::chacha_round(r_w, r_rnd[0]);
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == LastRnd) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                ks_we   = 1'b1;
                ks_word = fin_b[i_q_item.pos];
                if (out_free) begin
                    emit    = 1'b1;
                    o_q_pop = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    o_q_pop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign res_word = i_q_item.mode ? (i_q_item.data ^ ks_word) : ks_word;

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_rnd <= n_rnd;
        if (ks_we) begin
            r_ks <= fin_b;
        end
        if (emit) begin
            r_out_data <= res_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_data_out = r_out_data;
    assign o_busy     = (r_state != S_IDLE);

endmodule

// File: src/chacha_keystream_xor_top.sv
// ----------------------------------------------------------------------------
// chacha_keystream_xor_top
// ChaCha keystream generator and combiner, one 64-bit word per request.
// ----------------------------------------------------------------------------
// The first word of each 64-byte block waits for the block function: a load
// step, ROUNDS rounded up to even round steps (one column or diagonal pass
// each in the single round unit) and a final add. The other seven words of
// the block come from the stored keystream. Requests queue up while a block
// is computed. A finished result waits in the output register until popped;
// while it waits, the core holds back its next result, so intake stops once
// the queue fills.
// Writing register 6 reloads the block counter and restarts at a new block.
module chacha_keystream_xor_top #(
    parameter int ROUNDS      = chkx_pkg::RoundsDefault,
    parameter int QUEUE_DEPTH = chkx_pkg::QueueDepthDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [chkx_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [63:0]                  i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic [63:0]                  i_data_in,
    input  logic                         i_mode,
    output logic                         empty,
    input  logic                         pop,
    output logic [63:0]                  o_data_out
);

    chkx_pkg::t_cfg_regs r_cfg;
    chkx_pkg::t_cfg_wr   cfg_wr;
    chkx_pkg::t_item     fq_item;
    chkx_pkg::t_item     q_head;
    chkx_pkg::t_state    init_s;
    logic                fq_push;
    logic                q_full;
    logic                q_empty;
    logic                q_pop;
    logic                back_busy;

    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.idx  = i_cfg_idx;
    assign cfg_wr.data = i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    // Register k holds state words 2k (low half) and 2k+1 (high half).
    assign init_s = r_cfg;

    chkx_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg_wr),
        .i_push    (push),
        .i_data_in (i_data_in),
        .i_mode    (i_mode),
        .i_q_full  (q_full),
        .o_full    (full),
        .o_q_push  (fq_push),
        .o_q_item  (fq_item)
    );

    chkx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_item  (fq_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (q_head)
    );

    chkx_back #(
        .ROUNDS (ROUNDS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_init     (init_s),
        .i_q_empty  (q_empty),
        .i_q_item   (q_head),
        .o_q_pop    (q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_data_out (o_data_out),
        .o_busy     (back_busy)
    );

    // The result register comes out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result visible right after reset");

    // The core only computes a block for a request still held in the queue.
    a_busy_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        back_busy |-> !q_empty)
        else $error("core busy with no queued request");

    // With nothing queued and the core idle, no result can appear.
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_empty && !back_busy && (empty || pop)) |=> empty)
        else $error("result produced without a request");

    // The core takes a request from the queue only when one is waiting.
    a_pop_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule
